[hw/rtl/wpt_pkg.sv]
package wpt_pkg;

	// Table geometry.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Request and response field widths.
	localparam int MODE_W   = 3;
	localparam int KEY_W    = 8;
	localparam int WEIGHT_W = 16;
	localparam int INDEX_W  = 4;
	localparam int DRAW_W   = 20;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int TOTAL_W  = 20;

	// Width of an exact sum over a full table, and compare widths.
	localparam int SUM_W   = WEIGHT_W + $clog2(DEPTH);
	localparam int ICMP_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;
	localparam int DCMP_W  = (DRAW_W > SUM_W) ? DRAW_W : SUM_W;

	typedef enum logic [MODE_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_MERGE   = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_COMPACT = 3'd3,
		OP_CLEAR   = 3'd4,
		OP_ROLL    = 3'd5,
		OP_LOOKUP  = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_INDEX = 2'd2,
		ST_DRAW  = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	// Broadcast to every cell: shift toward the head, and load one slot.
	typedef struct packed {
		logic             shift;
		logic             load;
		logic [IDX_W-1:0] slot;
		entry_t           data;
	} cell_ctrl_t;

endpackage

[hw/rtl/wpt_if.sv]
interface wpt_req_if;
	logic                          valid;
	logic                          ready;
	logic [wpt_pkg::MODE_W-1:0]    mode;
	logic [wpt_pkg::KEY_W-1:0]     key_in;
	logic [wpt_pkg::WEIGHT_W-1:0]  weight_in;
	logic [wpt_pkg::INDEX_W-1:0]   index_in;
	logic [wpt_pkg::DRAW_W-1:0]    draw;

	modport source (output valid, mode, key_in, weight_in, index_in, draw, input ready);
	modport sink (input valid, mode, key_in, weight_in, index_in, draw, output ready);
endinterface

interface wpt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [wpt_pkg::STATUS_W-1:0]  status;
	logic [wpt_pkg::KEY_W-1:0]     key_out;
	logic [wpt_pkg::WEIGHT_W-1:0]  weight_out;
	logic [wpt_pkg::COUNT_W-1:0]   entry_count;
	logic [wpt_pkg::TOTAL_W-1:0]   weight_total;

	modport source (output valid, status, key_out, weight_out, entry_count, weight_total,
		input ready);
	modport sink (input valid, status, key_out, weight_out, entry_count, weight_total,
		output ready);
endinterface

[hw/rtl/wpt_cell.sv]
module wpt_cell (
	input  logic                clk,
	input  wpt_pkg::cell_ctrl_t ctrl,
	input  logic [wpt_pkg::IDX_W-1:0] my_slot,
	input  wpt_pkg::entry_t     nbr,
	output wpt_pkg::entry_t     ent
);
	import wpt_pkg::*;

	entry_t ent_q;
	logic   load_here;

	assign load_here = ctrl.load && (ctrl.slot == my_slot);

	// A loaded slot takes the broadcast entry; otherwise it follows its neighbor or holds.
	always_ff @(posedge clk) begin
		if (load_here) begin
			ent_q <= ctrl.data;
		end else if (ctrl.shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;

endmodule

[hw/rtl/weighted_pick_table.sv]
// Weighted pick table: an ordered table of up to DEPTH (16) key/weight pairs with
// roulette-wheel selection. Each request carries a mode (append, merge, remove by
// index, compact, clear, roll, weight lookup) and returns exactly one response with a
// status, a key, a weight, and the entry count and total weight after the request.
// The entries live in a ring of identical cells that hands every entry one place
// toward the head each cycle of a ring walk; a single controller at the head examines
// one entry per cycle of the walk and writes it back at the tail, possibly changed or
// dropped. Clear, mode 7 and the early-out cases (full table, bad index, invalid draw,
// empty table) finish without a walk; append writes the tail slot directly; lookup,
// roll and compact walk the ring once; merge walks it once and then appends when it
// finds no match and the table has room; remove walks it twice, or once when it removes
// the only entry. A previous response that still waits in the output register holds a
// finished request back until it is taken.
// One request is worked on at a time, but a new request is accepted while the
// previous response still waits in the output register.
// The invalid_key register (reset 255) is written through cfg_wr_en/cfg_wr_data and
// should only change while the block is idle.
module weighted_pick_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [wpt_pkg::KEY_W-1:0] cfg_wr_data,
	wpt_req_if.sink                  req,
	wpt_rsp_if.source                rsp
);
	import wpt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ROT   = 4'b0010,
		S_WRITE = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	// Control state.
	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [KEY_W-1:0]     invkey_q;
	logic [CNT_W-1:0]     remain_q;
	logic [CNT_W-1:0]     pushed_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 found_q;
	logic                 phase_b_q;
	logic                 rsp_valid_q;

	// Request payload and working registers.
	op_t                  op_q;
	logic [KEY_W-1:0]     key_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [DRAW_W-1:0]    draw_q;
	entry_t               hold_q;
	logic [SUM_W-1:0]     run_q;
	logic [SUM_W-1:0]     acc_q;
	status_t              status_q;
	logic [KEY_W-1:0]     kout_q;
	logic [WEIGHT_W-1:0]  wout_q;

	// Response register.
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [KEY_W-1:0]     rsp_key_q;
	logic [WEIGHT_W-1:0]  rsp_weight_q;
	logic [COUNT_W-1:0]   rsp_count_q;
	logic [TOTAL_W-1:0]   rsp_total_q;

	// The ring of cells. Cell 0 is the head that the controller examines.
	entry_t               cells [DEPTH];
	entry_t               head;
	cell_ctrl_t           cell_ctrl;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			localparam int NXT = (gi + 1) % DEPTH;
			wpt_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl),
				.my_slot (IDX_W'(gi)),
				.nbr     (cells[NXT]),
				.ent     (cells[gi])
			);
		end
	endgenerate

	assign head = cells[0];

	// ------------------------------------------------------------------
	// Request acceptance and the first decision on the operation.
	// ------------------------------------------------------------------
	logic     req_fire;
	state_t   start_state;
	status_t  start_status;
	logic [KEY_W-1:0] start_kout;
	logic     count_empty;
	logic     count_full;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign count_empty = (count_q == '0);
	assign count_full  = (count_q == CNT_W'(DEPTH));

	always_comb begin
		start_state  = S_FIN;
		start_status = ST_OK;
		start_kout   = req.key_in;
		unique case (op_t'(req.mode))
			OP_APPEND: begin
				if (count_full) begin
					start_status = ST_FULL;
				end else begin
					start_state = S_WRITE;
				end
			end
			OP_MERGE: begin
				// An empty table cannot hold a match, so the pair is appended at once.
				start_state = count_empty ? S_WRITE : S_ROT;
			end
			OP_REMOVE: begin
				if (ICMP_W'(req.index_in) >= ICMP_W'(count_q)) begin
					start_status = ST_INDEX;
				end else begin
					start_state = S_ROT;
				end
			end
			OP_COMPACT, OP_LOOKUP: begin
				start_state = count_empty ? S_FIN : S_ROT;
			end
			OP_ROLL: begin
				start_kout = invkey_q;
				if ((sum_q == '0) || (DCMP_W'(req.draw) >= DCMP_W'(sum_q))) begin
					start_status = ST_DRAW;
				end else begin
					start_state = S_ROT;
				end
			end
			default: begin
				// Clear and the unused mode finish right away.
			end
		endcase
	end

	// ------------------------------------------------------------------
	// One step of a ring walk: the head entry is popped and, unless dropped,
	// pushed back at the tail right behind the entries already handled.
	// ------------------------------------------------------------------
	logic             rot_push;
	entry_t           rot_data;
	logic             rot_hit;
	logic             key_match;
	logic             last;
	logic [SUM_W-1:0] run_next;
	logic [CNT_W-1:0] pushed_next;
	logic [SUM_W-1:0] acc_next;
	logic [CNT_W-1:0] tail_pos;
	logic             found_next;

	assign key_match   = (head.key == key_q);
	assign last        = (remain_q == CNT_W'(1));
	assign run_next    = run_q + SUM_W'(head.weight);
	assign tail_pos    = remain_q - CNT_W'(1) + pushed_q;
	assign pushed_next = pushed_q + CNT_W'(rot_push);
	assign acc_next    = rot_push ? (acc_q + SUM_W'(rot_data.weight)) : acc_q;
	assign found_next  = found_q || rot_hit;

	always_comb begin
		rot_push = 1'b1;
		rot_data = head;
		rot_hit  = 1'b0;
		unique case (op_q)
			OP_MERGE: begin
				// The first matching entry absorbs the weight, wrapping at the field width.
				rot_hit = key_match && !found_q;
				if (rot_hit) begin
					rot_data.weight = head.weight + weight_q;
				end
			end
			OP_REMOVE: begin
				// First pass lifts the last entry out; second pass drops it into the hole.
				if (!phase_b_q) begin
					rot_push = !last;
				end else if (ICMP_W'(pos_q) == ICMP_W'(idx_q)) begin
					rot_data = hold_q;
				end
			end
			OP_COMPACT: begin
				rot_push = (head.weight != '0) && (head.key != invkey_q);
			end
			OP_ROLL: begin
				rot_hit = !found_q && (DCMP_W'(run_next) > DCMP_W'(draw_q));
			end
			OP_LOOKUP: begin
				rot_hit = !found_q && key_match;
			end
			default: begin
			end
		endcase
	end

	// Broadcast to the cells.
	always_comb begin
		cell_ctrl.shift = 1'b0;
		cell_ctrl.load  = 1'b0;
		cell_ctrl.slot  = tail_pos[IDX_W-1:0];
		cell_ctrl.data  = rot_data;
		unique case (state_q)
			S_ROT: begin
				cell_ctrl.shift = 1'b1;
				cell_ctrl.load  = rot_push;
			end
			S_WRITE: begin
				cell_ctrl.load  = 1'b1;
				cell_ctrl.slot  = count_q[IDX_W-1:0];
				cell_ctrl.data  = '{key: key_q, weight: weight_q};
			end
			default: begin
			end
		endcase
	end

	logic rsp_free;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			invkey_q    <= '1;
			remain_q    <= '0;
			pushed_q    <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			phase_b_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				invkey_q <= cfg_wr_data;
			end

			if ((state_q == S_FIN) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q   <= start_state;
						remain_q  <= count_q;
						pushed_q  <= '0;
						pos_q     <= '0;
						found_q   <= 1'b0;
						phase_b_q <= 1'b0;
						if (op_t'(req.mode) == OP_CLEAR) begin
							count_q <= '0;
							sum_q   <= '0;
						end
					end
				end
				S_ROT: begin
					remain_q <= remain_q - CNT_W'(1);
					pushed_q <= pushed_next;
					pos_q    <= pos_q + CNT_W'(1);
					found_q  <= found_next;
					if (last) begin
						count_q <= pushed_next;
						sum_q   <= acc_next;
						if ((op_q == OP_REMOVE) && !phase_b_q) begin
							if (pushed_next == '0) begin
								state_q <= S_FIN;
							end else begin
								phase_b_q <= 1'b1;
								remain_q  <= pushed_next;
								pushed_q  <= '0;
								pos_q     <= '0;
							end
						end else if ((op_q == OP_MERGE) && !found_next &&
							(pushed_next != CNT_W'(DEPTH))) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(weight_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload and working registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					op_q     <= op_t'(req.mode);
					key_q    <= req.key_in;
					weight_q <= req.weight_in;
					idx_q    <= req.index_in;
					draw_q   <= req.draw;
					status_q <= start_status;
					kout_q   <= start_kout;
					wout_q   <= '0;
					run_q    <= '0;
					acc_q    <= '0;
				end
			end
			S_ROT: begin
				run_q <= run_next;
				acc_q <= acc_next;
				if ((op_q == OP_REMOVE) && !phase_b_q && last) begin
					hold_q <= head;
					acc_q  <= '0;
				end
				if (rot_hit && (op_q == OP_ROLL)) begin
					kout_q <= head.key;
				end
				if (rot_hit && (op_q == OP_LOOKUP)) begin
					wout_q <= head.weight;
				end
				if (last && (op_q == OP_MERGE) && !found_next &&
					(pushed_next == CNT_W'(DEPTH))) begin
					status_q <= ST_FULL;
				end
			end
			S_FIN: begin
				if (rsp_free) begin
					rsp_status_q <= status_q;
					rsp_key_q    <= kout_q;
					rsp_weight_q <= wout_q;
					rsp_count_q  <= COUNT_W'(count_q);
					rsp_total_q  <= TOTAL_W'(sum_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.key_out      = rsp_key_q;
	assign rsp.weight_out   = rsp_weight_q;
	assign rsp.entry_count  = rsp_count_q;
	assign rsp.weight_total = rsp_total_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("empty table with nonzero total weight");

	a_walk_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |-> ((remain_q != '0) &&
		((remain_q + pushed_q) <= CNT_W'(DEPTH))))
		else $error("ring walk overruns the table");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && rsp_free) |=> (rsp.valid && (state_q == S_IDLE)))
		else $error("finished request did not reach the response register");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import wpt_pkg::*;

	// Mode 7 has no operation behind it; the block must treat it as a no-op.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	// Settle time before a register write, above the slowest request (remove).
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 250;

	// One request as the driver sees it. When adapt is set, the driver fits the draw
	// of a roll or the index of a remove to the table contents at the moment the
	// request is presented, so that most of them land on live entries.
	typedef struct {
		logic [MODE_W-1:0]   mode;
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
		logic [INDEX_W-1:0]  index;
		logic [DRAW_W-1:0]   draw;
		bit                  adapt;
	} pick_cmd_t;

	typedef struct {
		status_t             status;
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
		logic [COUNT_W-1:0]  count;
		logic [TOTAL_W-1:0]  total;
	} pick_reply_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [KEY_W-1:0] cfg_wr_data;

	wpt_req_if req_ch ();
	wpt_rsp_if rsp_ch ();

	weighted_pick_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	// Shadow copy of the table and of the invalid_key register.
	logic [KEY_W-1:0]    tbl_key    [DEPTH];
	logic [WEIGHT_W-1:0] tbl_weight [DEPTH];
	int                  tbl_count;
	logic [KEY_W-1:0]    shadow_invalid_key;

	pick_cmd_t   pending_cmds [$];
	pick_reply_t expected_replies [$];
	pick_cmd_t   active_cmd;
	pick_cmd_t   next_cmd;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;

	// A few keys that recur often, so that merges and lookups find matches.
	logic [KEY_W-1:0] hot_keys [6] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h3C};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Table predictor
	// ------------------------------------------------------------------

	// Sum of all live weights. A full table of maximum weights still fits in 20 bits.
	function automatic int table_total();
		int sum;
		sum = 0;
		for (int i = 0; i < tbl_count; i++)
			sum += tbl_weight[i];
		return sum;
	endfunction

	// Position of the first entry carrying the key, or -1 when there is none.
	function automatic int find_entry(logic [KEY_W-1:0] k);
		int pos;
		pos = -1;
		for (int i = tbl_count - 1; i >= 0; i--)
			if (tbl_key[i] == k)
				pos = i;
		return pos;
	endfunction

	function automatic status_t table_append(logic [KEY_W-1:0] k, logic [WEIGHT_W-1:0] w);
		if (tbl_count >= DEPTH)
			return ST_FULL;
		tbl_key[tbl_count] = k;
		tbl_weight[tbl_count] = w;
		tbl_count++;
		return ST_OK;
	endfunction

	// Applies one request to the shadow table and returns the reply it must produce.
	function automatic pick_reply_t apply_request(pick_cmd_t c);
		pick_reply_t r;
		int pos;
		int keep;
		int total;
		int run;
		bit picked;
		r.status = ST_OK;
		r.key = c.key;
		r.weight = '0;
		case (c.mode)
			OP_APPEND: r.status = table_append(c.key, c.weight);
			OP_MERGE: begin
				pos = find_entry(c.key);
				// The weight of an existing entry wraps at 16 bits.
				if (pos >= 0)
					tbl_weight[pos] = tbl_weight[pos] + c.weight;
				else
					r.status = table_append(c.key, c.weight);
			end
			OP_REMOVE: begin
				if (c.index >= tbl_count) begin
					r.status = ST_INDEX;
				end else begin
					tbl_key[c.index] = tbl_key[tbl_count - 1];
					tbl_weight[c.index] = tbl_weight[tbl_count - 1];
					tbl_count--;
				end
			end
			OP_COMPACT: begin
				keep = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_weight[i] != '0 && tbl_key[i] != shadow_invalid_key) begin
						tbl_key[keep] = tbl_key[i];
						tbl_weight[keep] = tbl_weight[i];
						keep++;
					end
				end
				tbl_count = keep;
			end
			OP_CLEAR: tbl_count = 0;
			OP_ROLL: begin
				total = table_total();
				r.key = shadow_invalid_key;
				if (total == 0 || c.draw >= total) begin
					r.status = ST_DRAW;
				end else begin
					run = 0;
					picked = 1'b0;
					for (int i = 0; i < tbl_count; i++) begin
						run += tbl_weight[i];
						if (!picked && run > c.draw) begin
							r.key = tbl_key[i];
							picked = 1'b1;
						end
					end
				end
			end
			OP_LOOKUP: begin
				pos = find_entry(c.key);
				if (pos >= 0)
					r.weight = tbl_weight[pos];
			end
			default: ;
		endcase
		r.count = COUNT_W'(tbl_count);
		r.total = TOTAL_W'(table_total());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// The prediction for an accepted request is made before the next request is
	// taken from the queue, so an adapted draw or index sees the table exactly as
	// the block will see it.
	always @(posedge clk) begin : req_driver
		int total;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_replies.insert(expected_replies.size(), apply_request(active_cmd));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					if (next_cmd.adapt) begin
						total = table_total();
						if (next_cmd.mode == OP_ROLL) begin
							if (total == 0)
								next_cmd.draw = DRAW_W'($urandom_range(3));
							else case ($urandom_range(9))
								0: next_cmd.draw = DRAW_W'(total);
								1: next_cmd.draw = DRAW_W'(total - 1);
								default: next_cmd.draw = DRAW_W'($urandom_range(total - 1));
							endcase
						end else if (next_cmd.mode == OP_REMOVE && tbl_count > 0) begin
							next_cmd.index = INDEX_W'($urandom_range(tbl_count - 1));
						end
					end
					active_cmd = next_cmd;
					req_ch.valid     <= 1'b1;
					req_ch.mode      <= next_cmd.mode;
					req_ch.key_in    <= next_cmd.key;
					req_ch.weight_in <= next_cmd.weight;
					req_ch.index_in  <= next_cmd.index;
					req_ch.draw      <= next_cmd.draw;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Reply monitor
	// ------------------------------------------------------------------

	// Ready is redrawn every cycle; the block must hold its reply while it is low.
	always @(posedge clk) begin : rsp_monitor
		pick_reply_t want;
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: reply with no request pending: status %0d key %0h", $time,
					rsp_ch.status, rsp_ch.key_out);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.key_out !== want.key) begin
					$display("%0t: key_out expected %0h actual %0h", $time, want.key,
						rsp_ch.key_out);
					mismatch_count++;
				end
				if (rsp_ch.weight_out !== want.weight) begin
					$display("%0t: weight_out expected %0h actual %0h", $time, want.weight,
						rsp_ch.weight_out);
					mismatch_count++;
				end
				if (rsp_ch.entry_count !== want.count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time, want.count,
						rsp_ch.entry_count);
					mismatch_count++;
				end
				if (rsp_ch.weight_total !== want.total) begin
					$display("%0t: weight_total expected %0h actual %0h", $time, want.total,
						rsp_ch.weight_total);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_cmd(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
			logic [WEIGHT_W-1:0] weight, logic [INDEX_W-1:0] index,
			logic [DRAW_W-1:0] draw, bit adapt);
		pick_cmd_t c;
		c.mode = mode;
		c.key = key;
		c.weight = weight;
		c.index = index;
		c.draw = draw;
		c.adapt = adapt;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// Keys lean toward a small hot set and the current invalid key.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(7))
			0: return shadow_invalid_key;
			1, 2, 3, 4: return hot_keys[$urandom_range(5)];
			default: return KEY_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return WEIGHT_W'($urandom_range(15, 1));
			default: return WEIGHT_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		return INDEX_W'($urandom_range(15));
	endfunction

	function automatic logic [DRAW_W-1:0] pick_draw();
		return DRAW_W'($urandom_range(20'hFFFFF));
	endfunction

	task automatic push_noise();
		push_cmd(MODE_W'($urandom_range(7)), KEY_W'($urandom_range(255)),
			WEIGHT_W'($urandom_range(16'hFFFF)), pick_index(), pick_draw(), 1'b0);
	endtask

	// Random traffic is built from bursts: filling runs that can reach a full table,
	// runs of rolls against the live total, edits that shrink the table, lookups,
	// and a share of unconstrained noise.
	task automatic queue_random(int n_items);
		int pushed;
		int len;
		pushed = 0;
		while (pushed < n_items) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					len = $urandom_range(20, 4);
					for (int i = 0; i < len; i++)
						push_cmd($urandom_range(1) ? OP_MERGE : OP_APPEND, pick_key(),
							pick_weight(), pick_index(), pick_draw(), 1'b0);
				end
				3, 4: begin
					len = $urandom_range(10, 3);
					for (int i = 0; i < len; i++)
						push_cmd(OP_ROLL, pick_key(), WEIGHT_W'($urandom_range(16'hFFFF)),
							pick_index(), pick_draw(), $urandom_range(9) != 0);
				end
				5: begin
					len = $urandom_range(6, 2);
					for (int i = 0; i < len; i++)
						case ($urandom_range(9))
							0: push_cmd(OP_CLEAR, pick_key(), pick_weight(), pick_index(),
								pick_draw(), 1'b0);
							1, 2: push_cmd(OP_COMPACT, pick_key(), pick_weight(),
								pick_index(), pick_draw(), 1'b0);
							default: push_cmd(OP_REMOVE, pick_key(), pick_weight(),
								pick_index(), pick_draw(), $urandom_range(4) != 0);
						endcase
				end
				6: begin
					len = $urandom_range(8, 3);
					for (int i = 0; i < len; i++)
						push_cmd(OP_LOOKUP, pick_key(), pick_weight(), pick_index(),
							pick_draw(), 1'b0);
				end
				default: begin
					len = $urandom_range(15, 5);
					for (int i = 0; i < len; i++)
						push_noise();
				end
			endcase
			pushed += len;
		end
	endtask

	// Waits until every request has been taken and answered, then lets the block settle.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || req_ch.valid || expected_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The register is only written while no request is in the block.
	task automatic write_invalid_key(logic [KEY_W-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_invalid_key = value;
	endtask

	task automatic run_phase(logic [KEY_W-1:0] inv_key, int send_pct, int recv_pct);
		write_invalid_key(inv_key);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		queue_random(ITEMS_PER_PHASE);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = '0;
		req_ch.key_in = '0;
		req_ch.weight_in = '0;
		req_ch.index_in = '0;
		req_ch.draw = '0;
		rsp_ch.ready = 1'b0;
		tbl_count = 0;
		shadow_invalid_key = 8'hFF;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset value of invalid_key. The empty table is
		// probed first: a roll on it, a lookup, a remove with a bad index, the unused
		// mode and a clear. Then a merge that wraps a weight to zero, a merge that
		// has to append, a duplicate key that the lookup must not answer with, rolls
		// at the low and high ends of the draw, and a compact that drops both the
		// zero weights and the invalid key.
		push_cmd(OP_ROLL, 8'h00, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_LOOKUP, 8'h00, 16'hFFFF, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_REMOVE, 8'hFF, 16'h0000, 4'd0, 20'hFFFFF, 1'b0);
		push_cmd(MODE_UNUSED, 8'hA5, 16'hFFFF, 4'd15, 20'hFFFFF, 1'b0);
		push_cmd(OP_CLEAR, 8'h5A, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_APPEND, 8'h00, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_APPEND, 8'hFF, 16'hFFFF, 4'd15, 20'hFFFFF, 1'b0);
		push_cmd(OP_MERGE, 8'hFF, 16'h0001, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_MERGE, 8'h12, 16'h8000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_APPEND, 8'h12, 16'h0005, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_LOOKUP, 8'h12, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_ROLL, 8'h00, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_ROLL, 8'h00, 16'h0000, 4'd0, 20'h00000, 1'b1);
		push_cmd(OP_ROLL, 8'h00, 16'h0000, 4'd0, 20'hFFFFF, 1'b0);
		push_cmd(OP_COMPACT, 8'h00, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_LOOKUP, 8'hFF, 16'h0000, 4'd0, 20'h00000, 1'b0);
		push_cmd(OP_REMOVE, 8'h33, 16'h0000, 4'd15, 20'h00000, 1'b0);
		push_cmd(OP_REMOVE, 8'h33, 16'h0000, 4'd0, 20'h00000, 1'b0);
		wait_drained();

		// Random phases, each under its own invalid_key and its own idle pattern.
		run_phase(8'h00, 0, 0);
		run_phase(KEY_W'($urandom_range(254, 1)), 80, 0);
		run_phase(8'hFF, 0, 80);
		run_phase(KEY_W'($urandom_range(255)), 11, 11);

		if (mismatch_count == 0 && expected_replies.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[weighted_pick_table.f]
hw/rtl/wpt_pkg.sv
hw/rtl/wpt_if.sv
hw/rtl/wpt_cell.sv
hw/rtl/weighted_pick_table.sv
tb/tb_top.sv
